// ----- hdl/woc_pkg.sv -----
// ----------------------------------------------------------------------------
// woc_pkg
// Shared constants, types and helpers of the word occurrence counter.
// ----------------------------------------------------------------------------
package woc_pkg;

  // Sizes of the pattern store, the window and the saturating total.
  localparam int MaxPattern = 64;
  localparam int MaxText    = 4096;

  // Field widths.
  localparam int LenWidth    = 7;
  localparam int PosWidth    = 6;
  localparam int ByteWidth   = 8;
  localparam int TotalWidth  = 13;
  localparam int NewWidth    = 2;
  localparam int InTdataWidth  = 16;
  localparam int OutTdataWidth = 16;

  // Default depth of the queue between front and back.
  localparam int QueueDepth = 4;

  // Reset value of the pattern length register.
  localparam logic [LenWidth-1:0] PatternLengthReset = 7'd1;

  // Operation codes carried in tuser.
  localparam logic OpLoad = 1'b0;
  localparam logic OpText = 1'b1;

  // Delimiter characters that close an occurrence.
  localparam logic [ByteWidth-1:0] CharNul   = 8'h00;
  localparam logic [ByteWidth-1:0] CharTab   = 8'h09;
  localparam logic [ByteWidth-1:0] CharSpace = 8'h20;
  localparam logic [ByteWidth-1:0] CharSemi  = 8'h3B;

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic                 is_text;
    logic [PosWidth-1:0]  pos;
    logic [ByteWidth-1:0] data;
    logic                 last;
    logic                 delim;
  } woc_item_t;

  // True for a byte that may follow an occurrence.
  function automatic logic is_delimiter(input logic [ByteWidth-1:0] b);
    return (b == CharNul) || (b == CharTab) || (b == CharSpace) || (b == CharSemi);
  endfunction

endpackage

// ----- hdl/word_occurrence_counter.sv -----
// ----------------------------------------------------------------------------
// word_occurrence_counter
// Counts delimited occurrences of a loaded pattern in a stream of text bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): tuser selects the transaction kind. A pattern
//   load writes data_byte at pattern_position; a text byte enters the match
//   window, and tlast marks the final byte of a text.
//   Configuration: cfg_wen writes cfg_wdata into the pattern length register
//   (reset value 1); write it only while no text is in flight.
//   Output stream (m_axis_*): one transaction per finished text, with the
//   matches completed by its final byte and the saturating total.
// Flow and throughput:
//   A final text byte passes the queue, and its result is registered when
//   the back end takes it. Text bytes are taken at one per cycle, unless a
//   full result register or realignment holds them, through a 64-byte
//   shift window with two comparators per window byte. A text byte that
//   follows a pattern load or length write directly waits for realignment.
// Reset and stalls:
//   Reset empties the queue, the window and the result register, clears the
//   total and sets the pattern length to 1; pattern bytes must be loaded again.
//   While the receiver stalls, the result is held, text bytes keep flowing
//   until the next final byte, and the queue then fills and drops tready.
// ----------------------------------------------------------------------------
module word_occurrence_counter #(
  parameter int QUEUE_DEPTH = woc_pkg::QueueDepth
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream; tdata: pattern_position [5:0], data_byte [13:6], zero fill.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [woc_pkg::InTdataWidth-1:0]    s_axis_tdata,
  input  logic                                s_axis_tuser,  // operation
  input  logic                                s_axis_tlast,  // last_of_text
  // Pattern length register.
  input  logic                                cfg_wen,
  input  logic [woc_pkg::LenWidth-1:0]        cfg_wdata,
  // Result stream; tdata: new_matches [1:0], match_total [14:2], zero fill.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [woc_pkg::OutTdataWidth-1:0]   m_axis_tdata,
  output logic                                m_axis_tlast   // end_of_text
);
  import woc_pkg::*;

  woc_item_t in_item;
  woc_item_t head_item;
  logic      queue_full;
  logic      queue_push;
  logic      queue_pop;
  logic      head_valid;

  // Front end: accept and classify.
  woc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .full          (queue_full),
    .push          (queue_push),
    .item          (in_item)
  );

  // Queue between front and back.
  woc_fifo #(
    .WIDTH ($bits(woc_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (queue_push),
    .wr_data  (in_item),
    .full     (queue_full),
    .pop      (queue_pop),
    .rd_valid (head_valid),
    .rd_data  (head_item)
  );

  // Back end: matching, counting and results.
  woc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .head_valid    (head_valid),
    .head          (head_item),
    .pop           (queue_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- hdl/woc_front.sv -----
// ----------------------------------------------------------------------------
// woc_front
// Accepts input transactions, unpacks them and classifies text bytes.
// ----------------------------------------------------------------------------
module woc_front (
  // Input stream; tdata: pattern_position [5:0], data_byte [13:6], zero fill.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [woc_pkg::InTdataWidth-1:0]   s_axis_tdata,
  input  logic                               s_axis_tuser,  // operation
  input  logic                               s_axis_tlast,  // last_of_text
  // Queue write side.
  input  logic                               full,
  output logic                               push,
  output woc_pkg::woc_item_t                 item
);
  import woc_pkg::*;

  logic [ByteWidth-1:0] data_byte;

  // Accept whenever the queue has room.
  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  // Unpack the fields and mark delimiter bytes for the back end.
  assign data_byte    = s_axis_tdata[PosWidth +: ByteWidth];
  assign item.is_text = (s_axis_tuser == OpText);
  assign item.pos     = s_axis_tdata[PosWidth-1:0];
  assign item.data    = data_byte;
  assign item.last    = s_axis_tlast;
  assign item.delim   = is_delimiter(data_byte);

endmodule

// ----- hdl/woc_fifo.sv -----
// ----------------------------------------------------------------------------
// woc_fifo
// Small first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module woc_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CountWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(DEPTH - 1);
  localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

  logic [WIDTH-1:0]      entries [DEPTH];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [CountWidth-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full     = (count == FullCount);
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- hdl/woc_back.sv -----
// ----------------------------------------------------------------------------
// woc_back
// Pattern store, text window, parallel comparators, running total and the
// result register.
// ----------------------------------------------------------------------------
module woc_back (
  input  logic                                clk,
  input  logic                                rst,
  // Pattern length register.
  input  logic                                cfg_wen,
  input  logic [woc_pkg::LenWidth-1:0]        cfg_wdata,
  // Queue read side.
  input  logic                                head_valid,
  input  woc_pkg::woc_item_t                  head,
  output logic                                pop,
  // Result stream; tdata: new_matches [1:0], match_total [14:2], zero fill.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [woc_pkg::OutTdataWidth-1:0]   m_axis_tdata,
  output logic                                m_axis_tlast   // end_of_text
);
  import woc_pkg::*;

  localparam logic [LenWidth-1:0]   FullLen  = LenWidth'(MaxPattern);
  localparam logic [TotalWidth:0]   SatTotal = (TotalWidth + 1)'(MaxText);

  logic [LenWidth-1:0]       pattern_length;
  logic [ByteWidth-1:0]      pattern_store [MaxPattern];
  logic [ByteWidth-1:0]      window        [MaxPattern];
  logic [ByteWidth-1:0]      window_post   [MaxPattern];
  logic [LenWidth-1:0]       seen;
  logic [LenWidth-1:0]       seen_post;
  logic [TotalWidth-1:0]     running_total;
  logic [TotalWidth:0]       total_sum;
  logic [TotalWidth-1:0]     total_next;
  logic                      hold;

  logic [LenWidth-1:0]       active_len;
  logic [LenWidth-1:0]       active_len_next;
  logic [LenWidth-1:0]       shift_bytes;
  logic [MaxPattern-1:0]     len_mask;
  logic [MaxPattern-1:0]     len_mask_next;
  logic [ByteWidth*MaxPattern-1:0] rev_flat;
  logic [ByteWidth*MaxPattern-1:0] aligned;
  logic [ByteWidth*MaxPattern-1:0] aligned_next;

  logic [MaxPattern-1:0]     eq_pre;
  logic [MaxPattern-1:0]     eq_post;
  logic                      match_pre;
  logic                      match_post;
  logic [NewWidth-1:0]       fresh;

  logic                      out_free;
  logic                      blocked;
  logic                      do_text;
  logic                      do_last;
  logic                      do_load;
  logic                      out_valid;
  logic [NewWidth-1:0]       out_new;
  logic [TotalWidth-1:0]     out_total;

  // Pattern aligned to the window: entry k holds pattern byte len-1-k.
  always_comb begin
    active_len_next = (pattern_length > FullLen) ? FullLen : pattern_length;
    shift_bytes     = FullLen - active_len_next;
    for (int j = 0; j < MaxPattern; j++) begin
      rev_flat[ByteWidth*j +: ByteWidth] = pattern_store[MaxPattern-1-j];
    end
    aligned_next  = rev_flat >> {shift_bytes, 3'b000};
    len_mask_next = ~({MaxPattern{1'b1}} << active_len_next);
  end

  // Window after the current byte is shifted in.
  always_comb begin
    window_post[0] = head.data;
    for (int k = 1; k < MaxPattern; k++) begin
      window_post[k] = window[k-1];
    end
    seen_post = (seen == FullLen) ? seen : seen + 1'b1;
  end

  // Parallel comparators on the window before and after the shift.
  always_comb begin
    for (int k = 0; k < MaxPattern; k++) begin
      eq_pre[k]  = !len_mask[k] || (window[k] == aligned[ByteWidth*k +: ByteWidth]);
      eq_post[k] = !len_mask[k] ||
                   (window_post[k] == aligned[ByteWidth*k +: ByteWidth]);
    end
    match_pre  = head.delim && (active_len != '0) && (seen >= active_len) && (&eq_pre);
    match_post = head.last && (active_len != '0) && (seen_post >= active_len) &&
                 (&eq_post);
    fresh      = {1'b0, match_pre} + {1'b0, match_post};
    total_sum  = {1'b0, running_total} + (TotalWidth + 1)'(fresh);
    total_next = (total_sum > SatTotal) ? SatTotal[TotalWidth-1:0]
                                        : total_sum[TotalWidth-1:0];
  end

  // Take the head item unless a text byte must wait for fresh alignment or
  // for room in the result register.
  assign out_free = !out_valid || m_axis_tready;
  assign blocked  = head.is_text && (hold || (head.last && !out_free));
  assign pop      = head_valid && !blocked;
  assign do_text  = pop && head.is_text;
  assign do_last  = do_text && head.last;
  assign do_load  = pop && !head.is_text;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= PatternLengthReset;
      seen           <= '0;
      running_total  <= '0;
      hold           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wen) begin
        pattern_length <= cfg_wdata;
      end
      hold <= do_load || cfg_wen;
      if (do_text) begin
        seen          <= head.last ? '0 : seen_post;
        running_total <= head.last ? '0 : total_next;
      end
      if (do_last) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    active_len <= active_len_next;
    len_mask   <= len_mask_next;
    aligned    <= aligned_next;
    if (do_load) begin
      pattern_store[head.pos] <= head.data;
    end
    if (do_text) begin
      window <= window_post;
    end
    if (do_last) begin
      out_new   <= fresh;
      out_total <= total_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutTdataWidth - NewWidth - TotalWidth){1'b0}}, out_total, out_new};
  assign m_axis_tlast  = 1'b1;

  // A finished text leaves the window empty and the total cleared.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    do_last |=> (seen == '0) && (running_total == '0))
    else $error("window or total not cleared after last text byte");

  // A text byte never uses the alignment in the cycle after a pattern load.
  a_wait_after_load: assert property (@(posedge clk) disable iff (rst)
    do_load |=> !(pop && head.is_text))
    else $error("text byte taken before pattern alignment settled");

  // Same after a pattern length write.
  a_wait_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_wen |=> !(pop && head.is_text))
    else $error("text byte taken before length alignment settled");

  // A result is held and never exceeds the saturation limit.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    do_last |=> m_axis_tvalid && (out_total <= SatTotal[TotalWidth-1:0]) &&
                (out_new != 2'b11))
    else $error("result missing or out of range");

endmodule

// ----- tb/sv/word_occurrence_counter_test.sv -----
// ----------------------------------------------------------------------------
// word_occurrence_counter_test
// Self-checking testbench of the word occurrence counter.
// ----------------------------------------------------------------------------
// A behavioral predictor follows every accepted input transaction and queues
// the result expected for each finished text. A checker compares each result
// transaction field by field with the oldest queued expectation. Directed
// texts cover the delimiters, the end-of-text match, the pattern length
// extremes and texts shorter than the pattern. Random phases then use random
// lengths and patterns with well-formed copies inside the texts. Both streams
// idle at random.
// ----------------------------------------------------------------------------
module word_occurrence_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import woc_pkg::*;

  localparam int CycleLimit  = 1000000;
  localparam int RandomItems = 1000;
  localparam int DrainCycles = 16;

  // Expected contents of one result transaction.
  typedef struct packed {
    logic [NewWidth-1:0]   fresh;
    logic [TotalWidth-1:0] total;
    logic                  done;
  } text_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [InTdataWidth-1:0]  s_axis_tdata = '0;
  logic                     s_axis_tuser = OpLoad;
  logic                     s_axis_tlast = 1'b0;
  logic                     cfg_wen = 1'b0;
  logic [LenWidth-1:0]      cfg_wdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OutTdataWidth-1:0] m_axis_tdata;
  logic                     m_axis_tlast;

  // Predictor state.
  logic [ByteWidth-1:0] pattern_mem [MaxPattern];
  logic [ByteWidth-1:0] window_mem [MaxPattern];
  int unsigned          window_fill = 0;
  int unsigned          occurrence_total = 0;
  logic [LenWidth-1:0]  length_reg = PatternLengthReset;
  text_result_t         pending_counts [$];

  // Run bookkeeping and idling controls.
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_gap_max = 16;
  int unsigned rx_gap_max = 16;
  int unsigned mid_load_pct = 0;
  int unsigned rx_stall = 0;

  word_occurrence_counter DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Free-running clock.
  always #10 clk = ~clk;

  // Pattern length as the matcher sees it.
  function automatic int unsigned used_length();
    return (length_reg > MaxPattern) ? MaxPattern : int'(length_reg);
  endfunction

  function automatic bit closes_word(input logic [ByteWidth-1:0] b);
    return (b == CharNul) || (b == CharSpace) || (b == CharSemi) || (b == CharTab);
  endfunction

  // True when the newest bytes of the current text spell the pattern.
  function automatic bit window_holds_pattern();
    int unsigned len;
    len = used_length();
    if (len == 0 || window_fill < len) return 1'b0;
    for (int k = 0; k < len; k++) begin
      if (window_mem[k] !== pattern_mem[len - 1 - k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void bump_total();
    if (occurrence_total < MaxText) occurrence_total++;
  endfunction

  // Advances the predictor by one accepted input transaction.
  function automatic void predict_match_count(input logic op, input logic [PosWidth-1:0] pos,
                                              input logic [ByteWidth-1:0] b, input logic last);
    text_result_t res;
    int unsigned  fresh;
    if (op == OpLoad) begin
      pattern_mem[pos] = b;
    end else begin
      fresh = 0;
      // A delimiter closes an occurrence that ended on the previous byte.
      if (closes_word(b) && window_holds_pattern()) begin
        bump_total();
        fresh++;
      end
      for (int k = MaxPattern - 1; k > 0; k--) window_mem[k] = window_mem[k - 1];
      window_mem[0] = b;
      if (window_fill < MaxPattern) window_fill++;
      if (last) begin
        // The end of the text closes an occurrence as well.
        if (window_holds_pattern()) begin
          bump_total();
          fresh++;
        end
        res.fresh = fresh[NewWidth-1:0];
        res.total = occurrence_total[TotalWidth-1:0];
        res.done  = 1'b1;
        pending_counts.push_back(res);
        for (int k = 0; k < MaxPattern; k++) window_mem[k] = '0;
        window_fill = 0;
        occurrence_total = 0;
      end
    end
  endfunction

  function automatic logic [ByteWidth-1:0] pick_delimiter();
    case ($urandom_range(0, 3))
      0: return CharNul;
      1: return CharTab;
      2: return CharSpace;
      default: return CharSemi;
    endcase
  endfunction

  // Pattern bytes come mostly from a tiny alphabet so that texts match often.
  function automatic logic [ByteWidth-1:0] random_pattern_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return ByteWidth'(8'h61 + $urandom_range(0, 2));
    else if (r < 80) return pick_delimiter();
    else return ByteWidth'($urandom_range(0, 255));
  endfunction

  // Sends one input transaction after a random gap and waits for acceptance.
  task automatic send_item(input logic op, input logic [PosWidth-1:0] pos,
                           input logic [ByteWidth-1:0] b, input logic last);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {{(InTdataWidth - PosWidth - ByteWidth){1'b0}}, b, pos};
    do @(posedge clk); while (!s_axis_tready);
    predict_match_count(op, pos, b, last);
    items_sent++;
  endtask

  // The last flag is ignored on a load, so it is driven at random.
  task automatic load_byte(input logic [PosWidth-1:0] pos, input logic [ByteWidth-1:0] b);
    send_item(OpLoad, pos, b, 1'($urandom_range(0, 1)));
  endtask

  // Sends one text, with optional pattern loads slipped in before any of its bytes.
  task automatic send_text(input logic [ByteWidth-1:0] text [$]);
    for (int i = 0; i < text.size(); i++) begin
      if ($urandom_range(0, 99) < mid_load_pct)
        load_byte(PosWidth'($urandom_range(0, MaxPattern - 1)), random_pattern_byte());
      send_item(OpText, PosWidth'($urandom_range(0, MaxPattern - 1)), text[i],
                i == text.size() - 1);
    end
  endtask

  // Stops sending until every expected result is in and the block is quiet.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_length(input logic [LenWidth-1:0] value);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    length_reg = value;
  endtask

  // Builds a text of pattern copies, partial copies, delimiters and noise.
  task automatic build_text(output logic [ByteWidth-1:0] text [$]);
    int unsigned alen;
    int unsigned n;
    int unsigned r;
    int unsigned cut;
    text = {};
    alen = (used_length() == 0) ? 3 : used_length();
    n = $urandom_range(1, (alen * 3 + 8 > 200) ? 200 : alen * 3 + 8);
    while (text.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        for (int k = 0; k < alen; k++) text.push_back(pattern_mem[k]);
      end else if (r < 55) begin
        cut = $urandom_range(0, alen - 1);
        for (int k = 0; k < cut; k++) text.push_back(pattern_mem[k]);
      end else if (r < 75) begin
        text.push_back(pick_delimiter());
      end else if (r < 92) begin
        text.push_back(ByteWidth'(8'h61 + $urandom_range(0, 2)));
      end else begin
        text.push_back(ByteWidth'($urandom_range(0, 255)));
      end
    end
    while (text.size() > n) void'(text.pop_back());
  endtask

  // Writes every pattern entry once, so no unwritten entry is ever matched.
  task automatic test_pattern_load();
    load_byte(0, 8'h61);
    load_byte(1, 8'h62);
    load_byte(2, 8'h63);
    for (int p = 3; p < MaxPattern - 2; p++) load_byte(PosWidth'(p), random_pattern_byte());
    load_byte(PosWidth'(MaxPattern - 2), 8'h00);
    load_byte(PosWidth'(MaxPattern - 1), 8'hFF);
  endtask

  // Each delimiter and the end of the text close a one-byte pattern.
  task automatic test_delimiters();
    send_text('{8'h61});
    send_text('{8'h61, CharSpace, 8'h61, CharSemi});
    send_text('{8'h61, CharTab, 8'h61, CharNul, 8'h61});
    send_text('{8'hFF, 8'h61, 8'h62});
  endtask

  // Zero length never matches; lengths above the store act as the full store.
  task automatic test_length_extremes();
    logic [ByteWidth-1:0] text [$];
    write_length('0);
    send_text('{8'h61, CharSpace});
    write_length({LenWidth{1'b1}});
    text = {};
    for (int k = 0; k < MaxPattern; k++) text.push_back(pattern_mem[k]);
    send_text(text);
  endtask

  // Bytes of an earlier text never complete an occurrence in the next one.
  task automatic test_short_text();
    write_length(3);
    send_text('{8'h61});
    send_text('{8'h62, 8'h63});
  endtask

  // Random phases with random lengths, patterns, texts and idling.
  task automatic test_random_traffic();
    logic [ByteWidth-1:0] text [$];
    int unsigned          target;
    int unsigned          r;
    int unsigned          len;
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 6);
      else if (r < 85) len = $urandom_range(7, MaxPattern);
      else if (r < 90) len = MaxPattern;
      else if (r < 94) len = 0;
      else if (r < 97) len = $urandom_range(MaxPattern + 1, 127);
      else len = 1;
      write_length(LenWidth'(len));
      if ($urandom_range(0, 1) == 1) begin
        for (int p = 0; p < ((len == 0 || len > 8) ? 8 : len); p++)
          load_byte(PosWidth'(p), random_pattern_byte());
      end
      tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 16;
      rx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 16;
      mid_load_pct = ($urandom_range(0, 4) == 0) ? 3 : 0;
      repeat ($urandom_range(2, 6)) begin
        if (items_sent < target) begin
          build_text(text);
          send_text(text);
        end
      end
    end
    mid_load_pct = 0;
  endtask

  // Result side: random stalls and the check of every result transaction.
  always @(posedge clk) begin : result_check
    text_result_t want;
    text_result_t got;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_stall = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      got.fresh = m_axis_tdata[NewWidth-1:0];
      got.total = m_axis_tdata[NewWidth +: TotalWidth];
      got.done  = m_axis_tlast;
      results_checked++;
      if (pending_counts.size() == 0) begin
        $display("%0t: result with nothing expected, new_matches %0d match_total %0d",
                 $time, got.fresh, got.total);
        error_count++;
      end else begin
        want = pending_counts.pop_front();
        if (got.fresh !== want.fresh) begin
          $display("%0t: new_matches expected %0d actual %0d", $time, want.fresh, got.fresh);
          error_count++;
        end
        if (got.total !== want.total) begin
          $display("%0t: match_total expected %0d actual %0d", $time, want.total, got.total);
          error_count++;
        end
        if (got.done !== want.done) begin
          $display("%0t: end_of_text expected %0b actual %0b", $time, want.done, got.done);
          error_count++;
        end
      end
      rx_stall = $urandom_range(0, rx_gap_max);
      m_axis_tready <= (rx_stall == 0);
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= (rx_stall == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Test sequence.
  initial begin
    for (int k = 0; k < MaxPattern; k++) begin
      pattern_mem[k] = '0;
      window_mem[k]  = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pattern_load();
    test_delimiters();
    test_length_extremes();
    test_short_text();
    test_random_traffic();
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (pending_counts.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_counts.size());
      error_count++;
    end
    $display("Sent %0d input transactions and checked %0d result transactions.",
             items_sent, results_checked);
    $display("Pattern lengths from 0 to 127, every delimiter and short texts were exercised.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/woc_pkg.sv
hdl/woc_front.sv
hdl/woc_fifo.sv
hdl/woc_back.sv
hdl/word_occurrence_counter.sv
tb/sv/word_occurrence_counter_test.sv
